/* rtl/mf3_pkg.sv */
// Shared types and constants for the 3x3 median filter.
// Used by all mf3_* modules and by the top level; no dependencies.
`default_nettype none

package mf3_pkg;

  localparam int PIX_W       = 8;
  localparam int COORD_W     = 12;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;
    logic [PIX_W-1:0]   px;
    logic               emit;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } mf3_item_t;

  typedef struct packed {
    logic full;
    logic almost_full;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/median_filter_3x3_top.sv */
// Top level of the 3x3 median filter: front end, item queue and median back end.
// Depends on mf3_pkg, mf3_front, mf3_queue and mf3_back.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_ready/pixel, one per cycle when
//   the output side keeps up. Each pixel at row >= 2 and column >= 2 of the
//   configured frame yields one item on out_valid/out_ready: the median of the
//   3x3 window centred one row up and one column left, with centre_row,
//   centre_col and frame_last (set on the last item of the frame). Border
//   pixels yield nothing.
//   Throughput is one pixel per cycle while out_ready stays high. An accepted pixel
//   passes the line store read, queue, window, row sort, merge and output stages.
//   Width and height are written through cfg_we/cfg_index/cfg_data while no
//   item is in flight; out-of-range values are clamped to [3, 4096] (width also
//   to MAX_WIDTH). Indexes other than 0 and 1 are ignored.
//   Reset clears counters, window and pipeline; width returns to min(640, MAX_WIDTH),
//   height to 480. Line stores are not cleared; their contents only reach border
//   windows. When out_ready is low, the median pipeline and queue fill, then in_ready drops.
`default_nettype none

module median_filter_3x3_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mf3_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mf3_pkg::PIX_W-1:0]      pixel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mf3_pkg::PIX_W-1:0]           median_value,
  output logic [mf3_pkg::COORD_W-1:0]         centre_row,
  output logic [mf3_pkg::COORD_W-1:0]         centre_col,
  output logic                                frame_last
);

  mf3_pkg::q_status_t  q_stat;
  mf3_pkg::mf3_item_t  push_item, pop_item;
  logic                push, pop, pop_valid;

  mf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  mf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_stat    (q_stat),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  mf3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (pop_valid),
    .q_item       (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median_value (median_value),
    .centre_row   (centre_row),
    .centre_col   (centre_col),
    .frame_last   (frame_last)
  );

endmodule

`default_nettype wire

/* rtl/mf3_front.sv */
// Front end: configuration registers, raster counters, line stores and item tagging.
// Depends on mf3_pkg; feeds mf3_queue.
`default_nettype none

module mf3_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mf3_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [mf3_pkg::PIX_W-1:0]           pixel,
  input  wire mf3_pkg::q_status_t                  q_stat,
  output logic                                     push,
  output mf3_pkg::mf3_item_t                       push_item
);

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WLIM = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int WRST = (WLIM < 640) ? WLIM : 640;
  localparam logic [mf3_pkg::COORD_W-1:0] WM1_RST = mf3_pkg::COORD_W'(WRST - 1);
  localparam logic [mf3_pkg::COORD_W-1:0] HM1_RST = mf3_pkg::COORD_W'(479);

  function automatic logic [mf3_pkg::COORD_W-1:0] lim_m1(
    input logic [mf3_pkg::CFG_W-1:0] v,
    input logic [mf3_pkg::CFG_W-1:0] lim
  );
    logic [mf3_pkg::CFG_W-1:0] c;
    c = v;
    if (v < mf3_pkg::CFG_W'(3)) c = mf3_pkg::CFG_W'(3);
    else if (v > lim) c = lim;
    return mf3_pkg::COORD_W'(c - mf3_pkg::CFG_W'(1));
  endfunction

  logic [mf3_pkg::COORD_W-1:0] wm1, hm1;
  logic [mf3_pkg::COORD_W-1:0] col_count, row_count, col_next, row_next;
  logic                        accept;
  logic [AW-1:0]               rd_idx;
  logic                        emit, last;

  logic [mf3_pkg::PIX_W-1:0]   line_a [MAX_WIDTH];
  logic [mf3_pkg::PIX_W-1:0]   line_b [MAX_WIDTH];
  logic [mf3_pkg::PIX_W-1:0]   rd_a, rd_b, fwd_a, fwd_b;
  logic                        fwd_sel;

  logic                        s1_valid;
  logic [AW-1:0]               s1_idx;
  logic [mf3_pkg::PIX_W-1:0]   s1_px, s1_mid, s1_top;
  logic                        s1_emit, s1_last;
  logic [mf3_pkg::COORD_W-1:0] s1_row, s1_col;

  assign in_ready = !(q_stat.full || (s1_valid && q_stat.almost_full));
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= WM1_RST;
      hm1 <= HM1_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mf3_pkg::CFG_IMAGE_WIDTH:  wm1 <= lim_m1(cfg_data, mf3_pkg::CFG_W'(WLIM));
        mf3_pkg::CFG_IMAGE_HEIGHT: hm1 <= lim_m1(cfg_data, mf3_pkg::CFG_W'(4096));
        default: ;
      endcase
    end
  end

  always_comb begin
    col_next = col_count;
    row_next = row_count;
    if (accept) begin
      if (col_count >= wm1) begin
        col_next = '0;
        row_next = (row_count >= hm1) ? '0 : row_count + mf3_pkg::COORD_W'(1);
      end else begin
        col_next = col_count + mf3_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  assign rd_idx = (col_count <= wm1) ? AW'(col_count) : '0;
  assign emit   = (row_count >= mf3_pkg::COORD_W'(2)) && (row_count <= hm1) &&
                  (col_count >= mf3_pkg::COORD_W'(2)) && (col_count <= wm1);
  assign last   = (row_count == hm1) && (col_count == wm1);

  assign s1_mid = fwd_sel ? fwd_a : rd_a;
  assign s1_top = fwd_sel ? fwd_b : rd_b;

  // write back the previous item while reading for the current one
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_a[s1_idx] <= s1_px;
      line_b[s1_idx] <= s1_mid;
    end
    rd_a <= line_a[rd_idx];
    rd_b <= line_b[rd_idx];
  end

  always_ff @(posedge clk) begin
    fwd_sel <= s1_valid && (s1_idx == rd_idx);
    fwd_a   <= s1_px;
    fwd_b   <= s1_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx  <= rd_idx;
      s1_px   <= pixel;
      s1_emit <= emit;
      s1_last <= last;
      s1_row  <= row_count - mf3_pkg::COORD_W'(1);
      s1_col  <= col_count - mf3_pkg::COORD_W'(1);
    end
  end

  assign push           = s1_valid;
  assign push_item.top  = s1_top;
  assign push_item.mid  = s1_mid;
  assign push_item.px   = s1_px;
  assign push_item.emit = s1_emit;
  assign push_item.row  = s1_row;
  assign push_item.col  = s1_col;
  assign push_item.last = s1_last;

endmodule

`default_nettype wire

/* rtl/mf3_queue.sv */
// Short item queue between front end and median back end.
// Depends on mf3_pkg.
`default_nettype none

module mf3_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire mf3_pkg::mf3_item_t  push_item,
  output mf3_pkg::q_status_t       q_stat,
  output logic                     pop_valid,
  input  wire logic                pop,
  output mf3_pkg::mf3_item_t       pop_item
);

  mf3_pkg::mf3_item_t              slots [mf3_pkg::QUEUE_DEPTH];
  logic [mf3_pkg::QUEUE_AW-1:0]    wr_ptr, rd_ptr;
  logic [mf3_pkg::QUEUE_AW:0]      count;
  logic                            do_pop;

  assign do_pop             = pop && pop_valid;
  assign pop_valid          = (count != '0);
  assign pop_item           = slots[rd_ptr];
  assign q_stat.full        = (count == (mf3_pkg::QUEUE_AW+1)'(mf3_pkg::QUEUE_DEPTH));
  assign q_stat.almost_full = (count >= (mf3_pkg::QUEUE_AW+1)'(mf3_pkg::QUEUE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mf3_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + mf3_pkg::QUEUE_AW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + (mf3_pkg::QUEUE_AW+1)'(1);
        2'b01:   count <= count - (mf3_pkg::QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mf3_back.sv */
// Back end: 3x3 window, pipelined median network and output register.
// Depends on mf3_pkg; fed by mf3_queue.
`default_nettype none

module mf3_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire mf3_pkg::mf3_item_t            q_item,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [mf3_pkg::PIX_W-1:0]          median_value,
  output logic [mf3_pkg::COORD_W-1:0]        centre_row,
  output logic [mf3_pkg::COORD_W-1:0]        centre_col,
  output logic                               frame_last
);

  typedef logic [mf3_pkg::PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } s3_t;

  typedef struct packed {
    logic [mf3_pkg::COORD_W-1:0] row;
    logic [mf3_pkg::COORD_W-1:0] col;
    logic                        last;
  } tag_t;

  function automatic s3_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t x, y, z, t;
    s3_t  r;
    x = a;
    y = b;
    z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin t = y; y = z; z = t; end
    if (x > y) begin t = x; x = y; y = t; end
    r.lo = x;
    r.md = y;
    r.hi = z;
    return r;
  endfunction

  pix_t  win [9];
  logic  vw, v1, v2, v3;
  logic  rdy1, rdy2, rdy3, rdyw;
  tag_t  tag_w, tag_1, tag_2, tag_3;
  s3_t   rows1 [3];
  s3_t   agg_lo, agg_md, agg_hi, fin;
  pix_t  lo2, md2, hi2, med3;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdyw = !vw || rdy1;
  assign pop  = q_valid && rdyw;

  // shift the window on every item, emitting or not
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (pop) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= q_item.top;
      win[5] <= q_item.mid;
      win[8] <= q_item.px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdyw) vw <= pop && q_item.emit;
      if (rdy1) v1 <= vw;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tag_w.row  <= q_item.row;
      tag_w.col  <= q_item.col;
      tag_w.last <= q_item.last;
    end
  end

  // sort each window row
  always_ff @(posedge clk) begin
    if (rdy1) begin
      tag_1 <= tag_w;
      for (int r = 0; r < 3; r++) begin
        rows1[r] <= sort3(win[r*3], win[r*3+1], win[r*3+2]);
      end
    end
  end

  assign agg_lo = sort3(rows1[0].lo, rows1[1].lo, rows1[2].lo);
  assign agg_md = sort3(rows1[0].md, rows1[1].md, rows1[2].md);
  assign agg_hi = sort3(rows1[0].hi, rows1[1].hi, rows1[2].hi);

  // max of minima, median of medians, min of maxima
  always_ff @(posedge clk) begin
    if (rdy2) begin
      tag_2 <= tag_1;
      lo2   <= agg_lo.hi;
      md2   <= agg_md.md;
      hi2   <= agg_hi.lo;
    end
  end

  assign fin  = sort3(lo2, md2, hi2);
  assign med3 = fin.md;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      tag_3        <= tag_2;
      median_value <= med3;
    end
  end

  assign out_valid  = v3;
  assign centre_row = tag_3.row;
  assign centre_col = tag_3.col;
  assign frame_last = tag_3.last;

endmodule

`default_nettype wire

/* rtl/mf3_checker.sv */
// Port-level checks for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_filter_3x3_top.
`default_nettype none

module mf3_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [mf3_pkg::PIX_W-1:0]      median_value,
  input wire logic [mf3_pkg::COORD_W-1:0]    centre_row,
  input wire logic [mf3_pkg::COORD_W-1:0]    centre_col,
  input wire logic                           frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median_value) &&
      $stable(centre_row) && $stable(centre_col) && $stable(frame_last))
    else $error("result changed while stalled");

  a_no_border: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre_row != '0 && centre_col != '0)
    else $error("result for a border pixel");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre_row <= mf3_pkg::COORD_W'(4094) &&
      centre_col <= mf3_pkg::COORD_W'(4094))
    else $error("centre coordinate out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result too soon after reset");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .median_value (median_value),
  .centre_row   (centre_row),
  .centre_col   (centre_col),
  .frame_last   (frame_last)
);

`default_nettype wire
